FILE: src/rsi_pkg.sv
// Shared types, constants and saturation helpers for the ray/sphere block.
// No dependencies; imported by every module of the block.
package rsi_pkg;

   localparam int COORD_W     = 32;
   localparam int FRAC_W      = 16;
   localparam int RAD_W       = COORD_W - 1;
   localparam int WIDE_W      = 64;
   localparam int ROOT_W      = WIDE_W / 2;
   localparam int REM_W       = ROOT_W + 4;
   localparam int SQRT_STAGES = ROOT_W / 2;

   localparam logic signed [WIDE_W-1:0] WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] WIDE_MIN = {1'b1, {(WIDE_W-1){1'b0}}};
   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic signed [COORD_W-1:0] dir_x;
      logic signed [COORD_W-1:0] dir_y;
      logic signed [COORD_W-1:0] dir_z;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic [RAD_W-1:0]          sphere_radius;
   } rsi_req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } rsi_rsp_type;

   // values that ride alongside the square root pipeline
   typedef struct packed {
      logic [2:0][COORD_W-1:0]  o;
      logic [2:0][COORD_W-1:0]  d;
      logic signed [WIDE_W-1:0] b;
      logic                     live;
   } rsi_side_type;

   // clamp a two-bit-grown sum to the signed wide range
   function automatic logic signed [WIDE_W-1:0] sat_wide(input logic signed [WIDE_W+1:0] x);
      if (x > (WIDE_W+2)'(WIDE_MAX)) return WIDE_MAX;
      else if (x < (WIDE_W+2)'(WIDE_MIN)) return WIDE_MIN;
      else return x[WIDE_W-1:0];
   endfunction

   // clamp a point coordinate to the coordinate range
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W:0] x);
      if (x > (WIDE_W+1)'(COORD_MAX)) return COORD_MAX;
      else if (x < (WIDE_W+1)'(COORD_MIN)) return COORD_MIN;
      else return x[COORD_W-1:0];
   endfunction

endpackage

FILE: src/rsi_sqrt.sv
// Pipelined integer square root, two root bits per stage, with sideband.
// Depends on rsi_pkg.
module rsi_sqrt (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [rsi_pkg::WIDE_W-1:0] radicand,
   input  rsi_pkg::rsi_side_type      in_side,
   output logic                 out_valid,
   output logic [rsi_pkg::ROOT_W-1:0] root,
   output rsi_pkg::rsi_side_type      out_side
);
   import rsi_pkg::*;

   logic               v_ff    [SQRT_STAGES];
   logic [REM_W-1:0]   rem_ff  [SQRT_STAGES];
   logic [ROOT_W-1:0]  root_ff [SQRT_STAGES];
   logic [WIDE_W-1:0]  rad_ff  [SQRT_STAGES];
   rsi_side_type       side_ff [SQRT_STAGES];

   logic               v_in    [SQRT_STAGES];
   logic [REM_W-1:0]   rem_in  [SQRT_STAGES];
   logic [ROOT_W-1:0]  root_in [SQRT_STAGES];
   logic [WIDE_W-1:0]  rad_in  [SQRT_STAGES];
   rsi_side_type       side_in [SQRT_STAGES];

   // one restoring digit: bring down two radicand bits, try root*4+1
   function automatic logic [REM_W+ROOT_W-1:0] root_step(input logic [REM_W-1:0] rem,
                                                         input logic [ROOT_W-1:0] rt,
                                                         input logic [1:0] pair);
      logic [REM_W-1:0] acc;
      logic [REM_W-1:0] trial;
      acc   = {rem[REM_W-3:0], pair};
      trial = {2'b00, rt, 2'b01};
      if (acc >= trial) return {acc - trial, rt[ROOT_W-2:0], 1'b1};
      else return {acc, rt[ROOT_W-2:0], 1'b0};
   endfunction

   // compute every stage's next contents from the stage before it
   always_comb begin
      logic [REM_W-1:0]  rem_a;
      logic [ROOT_W-1:0] root_a;
      logic [WIDE_W-1:0] rad_a;
      logic [REM_W+ROOT_W-1:0] step;
      for (int k = 0; k < SQRT_STAGES; k++) begin
         if (k == 0) begin
            v_in[k]    = in_valid;
            side_in[k] = in_side;
            rem_a      = '0;
            root_a     = '0;
            rad_a      = radicand;
         end else begin
            v_in[k]    = v_ff[k-1];
            side_in[k] = side_ff[k-1];
            rem_a      = rem_ff[k-1];
            root_a     = root_ff[k-1];
            rad_a      = rad_ff[k-1];
         end
         step       = root_step(rem_a, root_a, rad_a[WIDE_W-1:WIDE_W-2]);
         step       = root_step(step[REM_W+ROOT_W-1:ROOT_W], step[ROOT_W-1:0],
                                rad_a[WIDE_W-3:WIDE_W-4]);
         rem_in[k]  = step[REM_W+ROOT_W-1:ROOT_W];
         root_in[k] = step[ROOT_W-1:0];
         rad_in[k]  = {rad_a[WIDE_W-5:0], 4'b0000};
      end
   end

   // advance valid bits under reset control
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQRT_STAGES; k++) v_ff[k] <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < SQRT_STAGES; k++) v_ff[k] <= v_in[k];
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SQRT_STAGES; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_valid = v_ff[SQRT_STAGES-1];
   assign root      = root_ff[SQRT_STAGES-1];
   assign out_side  = side_ff[SQRT_STAGES-1];

endmodule

FILE: src/ray_sphere_intersection.sv
// Top level of the ray/sphere intersection pipeline.
// Depends on rsi_pkg and rsi_sqrt.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   request | req_valid req_ready req_payload| in
//   result  | rsp_valid rsp_ready rsp_payload| out
//
// One ray enters per cycle while the result side does not stall.
// The pipeline is seven arithmetic stages, the sixteen-stage square root
// and three stages for t, the point products and the final sum.
// Reset clears all valid bits; payload registers are not reset.
// A stall on the result side freezes every stage at once, nothing is lost.
module ray_sphere_intersection (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rsi_pkg::rsi_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsi_pkg::rsi_rsp_type rsp_payload
);
   import rsi_pkg::*;

   logic en;
   logic rsp_valid_ff;
   rsi_rsp_type rsp_payload_ff, rsp_payload_in;

   logic signed [COORD_W-1:0] req_o [3];
   logic signed [COORD_W-1:0] req_d [3];
   logic signed [COORD_W-1:0] req_c [3];

   // stage valids before and after the root
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff;

   // coordinates carried down to the root
   logic signed [COORD_W-1:0] o1_ff [3], d1_ff [3], o2_ff [3], d2_ff [3];
   logic signed [COORD_W-1:0] o3_ff [3], d3_ff [3], o4_ff [3], d4_ff [3];
   logic signed [COORD_W-1:0] o5_ff [3], d5_ff [3], o6_ff [3], d6_ff [3];
   logic signed [COORD_W-1:0] o7_ff [3], d7_ff [3];

   logic signed [COORD_W:0]   l1_ff [3], l1_in [3];
   logic [RAD_W-1:0]          r1_ff;
   logic signed [WIDE_W-1:0]  pd2_ff [3], pd2_in [3];
   logic [WIDE_W-2:0]         cl2_ff [3], cl2_in [3];
   logic [2*RAD_W-1:0]        rr2_ff, rr3_ff;
   logic signed [WIDE_W-1:0]  b3_ff, pd3_ff;
   logic [WIDE_W-2:0]         cs3_ff, cs3_in;
   logic signed [WIDE_W-1:0]  b4_ff, c4_ff, b5_ff, c5_ff, b6_ff, c6_ff, b7_ff;
   logic [WIDE_W-1:0]         hh5_ff, hl5_ff, ll5_ff, hh5_in, hl5_in, ll5_in;
   logic [WIDE_W-2:0]         bb6_ff, bb6_in;
   logic [WIDE_W-1:0]         rad7_ff, rad7_in;
   logic                      live7_ff, live7_in;

   rsi_side_type              side7, side_q;
   logic                      vq;
   logic [ROOT_W-1:0]         root_q;

   logic signed [WIDE_W-1:0]  t8_ff, t8_in;
   logic                      hit8_ff, hit8_in, hit9_ff;
   logic signed [COORD_W-1:0] o8_ff [3], d8_ff [3], o9_ff [3];
   logic signed [WIDE_W-1:0]  ph9_ff [3], ph9_in [3];
   logic signed [WIDE_W:0]    pl9_ff [3], pl9_in [3];

   // whole pipeline moves when the output register can take a beat
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign req_o[0] = req_payload.origin_x;
   assign req_o[1] = req_payload.origin_y;
   assign req_o[2] = req_payload.origin_z;
   assign req_d[0] = req_payload.dir_x;
   assign req_d[1] = req_payload.dir_y;
   assign req_d[2] = req_payload.dir_z;
   assign req_c[0] = req_payload.center_x;
   assign req_c[1] = req_payload.center_y;
   assign req_c[2] = req_payload.center_z;

   // stage 1: offset from center; stage 2: dot and square products
   always_comb begin
      logic signed [WIDE_W:0]   pd;
      logic signed [WIDE_W+1:0] sq;
      for (int i = 0; i < 3; i++) begin
         l1_in[i]  = (COORD_W+1)'(req_o[i]) - (COORD_W+1)'(req_c[i]);
         pd        = (WIDE_W+1)'(d1_ff[i]) * (WIDE_W+1)'(l1_ff[i]);
         pd2_in[i] = pd[WIDE_W-1:0];
         sq        = (WIDE_W+2)'(l1_ff[i]) * (WIDE_W+2)'(l1_ff[i]);
         if (sq > (WIDE_W+2)'(WIDE_MAX)) cl2_in[i] = WIDE_MAX[WIDE_W-2:0];
         else cl2_in[i] = sq[WIDE_W-2:0];
      end
   end

   // stage 3: squared length, clamped (all terms are non-negative)
   always_comb begin
      logic [WIDE_W+1:0] s;
      s = (WIDE_W+2)'(cl2_ff[0]) + (WIDE_W+2)'(cl2_ff[1]) + (WIDE_W+2)'(cl2_ff[2]);
      if (s > (WIDE_W+2)'(WIDE_MAX)) cs3_in = WIDE_MAX[WIDE_W-2:0];
      else cs3_in = s[WIDE_W-2:0];
   end

   // stage 5: split |b| into halves for the square
   always_comb begin
      logic [WIDE_W-1:0] ub;
      ub     = b4_ff[WIDE_W-1] ? WIDE_W'(0) - WIDE_W'(b4_ff) : WIDE_W'(b4_ff);
      hh5_in = WIDE_W'(ub[WIDE_W-1:ROOT_W]) * WIDE_W'(ub[WIDE_W-1:ROOT_W]);
      hl5_in = WIDE_W'(ub[WIDE_W-1:ROOT_W]) * WIDE_W'(ub[ROOT_W-1:0]);
      ll5_in = WIDE_W'(ub[ROOT_W-1:0]) * WIDE_W'(ub[ROOT_W-1:0]);
   end

   // stage 6: b*b scaled down, clamped
   always_comb begin
      logic [2*WIDE_W-1:0] sq;
      logic [2*WIDE_W-2*FRAC_W-1:0] sh;
      sq = {hh5_ff, {WIDE_W{1'b0}}} + ((2*WIDE_W)'(hl5_ff) << (ROOT_W + 1))
         + (2*WIDE_W)'(ll5_ff);
      sh = sq[2*WIDE_W-1:2*FRAC_W];
      if (sh > (2*WIDE_W-2*FRAC_W)'(WIDE_MAX)) bb6_in = WIDE_MAX[WIDE_W-2:0];
      else bb6_in = sh[WIDE_W-2:0];
   end

   // stage 7: discriminant; a negative one feeds zero and marks no hit
   always_comb begin
      logic signed [WIDE_W:0] df;
      df = $signed({2'b00, bb6_ff}) - (WIDE_W+1)'(c6_ff);
      live7_in = !df[WIDE_W];
      if (df[WIDE_W]) rad7_in = '0;
      else if (df > (WIDE_W+1)'(WIDE_MAX)) rad7_in = WIDE_MAX;
      else rad7_in = df[WIDE_W-1:0];
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         side7.o[i] = o7_ff[i];
         side7.d[i] = d7_ff[i];
      end
      side7.b    = b7_ff;
      side7.live = live7_ff;
   end

   rsi_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v7_ff),
      .radicand  (rad7_ff),
      .in_side   (side7),
      .out_valid (vq),
      .root      (root_q),
      .out_side  (side_q)
   );

   // stage 8: t = -b - root, saturated
   always_comb begin
      logic signed [WIDE_W-1:0] nb;
      logic signed [WIDE_W:0]   tw;
      nb = (side_q.b == WIDE_MIN) ? WIDE_MAX : -side_q.b;
      tw = (WIDE_W+1)'(nb) - $signed({1'b0, (WIDE_W)'({root_q, {FRAC_W{1'b0}}})});
      if (tw < (WIDE_W+1)'(WIDE_MIN)) t8_in = WIDE_MIN;
      else t8_in = tw[WIDE_W-1:0];
      hit8_in = side_q.live && (t8_in > 0);
   end

   // stage 9: t*dir in two partial products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ph9_in[i] = WIDE_W'($signed({1'b0, t8_ff[WIDE_W-2:ROOT_W]})) * WIDE_W'(d8_ff[i]);
         pl9_in[i] = (WIDE_W+1)'($signed({1'b0, t8_ff[ROOT_W-1:0]})) * (WIDE_W+1)'(d8_ff[i]);
      end
   end

   // stage 10: rescale, add origin, clamp; zero the point on a miss
   always_comb begin
      logic signed [WIDE_W+ROOT_W:0] pw;
      logic signed [WIDE_W:0]        ps;
      logic signed [COORD_W-1:0]     pc [3];
      for (int i = 0; i < 3; i++) begin
         pw = ((WIDE_W+ROOT_W+1)'(ph9_ff[i]) <<< ROOT_W) + (WIDE_W+ROOT_W+1)'(pl9_ff[i]);
         ps = (WIDE_W+1)'(o9_ff[i]) + (WIDE_W+1)'(pw[WIDE_W+ROOT_W:2*FRAC_W]);
         pc[i] = hit9_ff ? sat_coord(ps) : '0;
      end
      rsp_payload_in.hit     = hit9_ff;
      rsp_payload_in.point_x = pc[0];
      rsp_payload_in.point_y = pc[1];
      rsp_payload_in.point_z = pc[2];
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         {v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff} <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= vq;
         v9_ff <= v8_ff;
         rsp_valid_ff <= v9_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            o1_ff[i] <= req_o[i];  d1_ff[i] <= req_d[i];
            o2_ff[i] <= o1_ff[i];  d2_ff[i] <= d1_ff[i];
            o3_ff[i] <= o2_ff[i];  d3_ff[i] <= d2_ff[i];
            o4_ff[i] <= o3_ff[i];  d4_ff[i] <= d3_ff[i];
            o5_ff[i] <= o4_ff[i];  d5_ff[i] <= d4_ff[i];
            o6_ff[i] <= o5_ff[i];  d6_ff[i] <= d5_ff[i];
            o7_ff[i] <= o6_ff[i];  d7_ff[i] <= d6_ff[i];
            l1_ff[i]  <= l1_in[i];
            pd2_ff[i] <= pd2_in[i];
            cl2_ff[i] <= cl2_in[i];
            o8_ff[i]  <= side_q.o[i];
            d8_ff[i]  <= side_q.d[i];
            o9_ff[i]  <= o8_ff[i];
            ph9_ff[i] <= ph9_in[i];
            pl9_ff[i] <= pl9_in[i];
         end
         r1_ff    <= req_payload.sphere_radius;
         rr2_ff   <= (2*RAD_W)'(r1_ff) * (2*RAD_W)'(r1_ff);
         rr3_ff   <= rr2_ff;
         b3_ff    <= sat_wide((WIDE_W+2)'(pd2_ff[0]) + (WIDE_W+2)'(pd2_ff[1]));
         pd3_ff   <= pd2_ff[2];
         cs3_ff   <= cs3_in;
         b4_ff    <= sat_wide((WIDE_W+2)'(b3_ff) + (WIDE_W+2)'(pd3_ff));
         c4_ff    <= $signed({1'b0, cs3_ff}) - $signed({2'b00, rr3_ff});
         b5_ff    <= b4_ff;
         c5_ff    <= c4_ff;
         hh5_ff   <= hh5_in;
         hl5_ff   <= hl5_in;
         ll5_ff   <= ll5_in;
         b6_ff    <= b5_ff;
         c6_ff    <= c5_ff;
         bb6_ff   <= bb6_in;
         b7_ff    <= b6_ff;
         rad7_ff  <= rad7_in;
         live7_ff <= live7_in;
         t8_ff    <= t8_in;
         hit8_ff  <= hit8_in;
         hit9_ff  <= hit8_ff;
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

FILE: src/rsi_checker.sv
// Port-level checks for the ray/sphere block, bound to its top level.
// Depends on rsi_pkg and ray_sphere_intersection.
module rsi_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input rsi_pkg::rsi_rsp_type rsp_payload
);
   import rsi_pkg::*;

   // drop results during reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed");

   // a miss carries a zero point
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.hit |->
         rsp_payload.point_x == 0 && rsp_payload.point_y == 0 && rsp_payload.point_z == 0)
      else $error("miss with nonzero point");

   // accept whenever the output side can drain
   a_ready: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request stalled while output free");

endmodule

bind ray_sphere_intersection rsi_checker u_rsi_checker (.*);
